// ===== src/assert_macros.svh =====
// Assertion macros used by the verification files of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: whenever ante holds, cons must hold as well.
`define BIA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication: whenever ante holds, cons must hold in the cycle after.
`define BIA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/bia_pkg.sv =====
package bia_pkg;

   // Field widths of the request, response and register words.
   localparam int CMD_W      = 2;
   localparam int ID_W       = 10;
   localparam int CSR_W      = 11;
   localparam int ST_W       = 2;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;
   localparam int RSP_PAD    = RSP_DATA_W - ST_W - ID_W;

   // Reset value of the id limit register.
   localparam int LIMIT_RESET = 1024;

   // Request commands.
   localparam logic [CMD_W-1:0] CMD_GET_LOW  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_GET_NEXT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PUT      = 2'd2;

   // Response status codes.
   localparam logic [ST_W-1:0] STS_OK   = 2'd0;
   localparam logic [ST_W-1:0] STS_BUSY = 2'd1;
   localparam logic [ST_W-1:0] STS_BAD  = 2'd2;

   // Sequencer states.
   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_SCAN,
      S_SEEK,
      S_FREE_CHK,
      S_DONE
   } state_type;

endpackage

// ===== src/bia_map_ram.sv =====
module bia_map_ram
   import bia_pkg::*;
#(
   parameter int DEPTH = 32,
   parameter int WIDTH = 32,
   parameter int AW    = 5
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read data is registered: it shows the word addressed in the previous cycle.
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/bia_word_scan.sv =====
module bia_word_scan
   import bia_pkg::*;
#(
   parameter int WORD_BITS = 32,
   parameter int CNT_W     = 11,
   localparam int BW       = $clog2(WORD_BITS)
) (
   input  logic [WORD_BITS-1:0] map_word,
   input  logic [CNT_W-1:0]     base,
   input  logic [BW-1:0]        lo,
   input  logic [CNT_W-1:0]     lim,
   output logic                 found,
   output logic [BW-1:0]        bit_idx
);

   logic [CNT_W-1:0]     span;
   logic [WORD_BITS-1:0] free_v;

   // Number of ids from this word's base up to the limit, zero if the limit lies at or below it.
   assign span = (lim > base) ? (lim - base) : '0;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         free_v[i] = !map_word[i] && (BW'(i) >= lo) && (CNT_W'(i) < span);
      end
   end

   // Lowest free bit wins.
   always_comb begin
      found   = 1'b0;
      bit_idx = '0;
      for (int i = WORD_BITS - 1; i >= 0; i--) begin
         if (free_v[i]) begin
            found   = 1'b1;
            bit_idx = BW'(i);
         end
      end
   end

endmodule

// ===== src/bitmap_id_allocator.sv =====
// Sequence: a get scans map words upward from its start word until it finds a free id below
// the limit, and answers busy if it runs out of words; a full map, an out-of-range free or an
// unknown command goes straight to the response; a free walks word bases up to the id's word.
// Throughput: one request at a time; the next is taken in the cycle after the response loads.
// Reset (synchronous, active high) clears the control state and starts a clearing pass
// over every map word, during which no request is taken.
module bitmap_id_allocator
   import bia_pkg::*;
#(
   parameter int MAX_IDS   = 1024,
   parameter int WORD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // cmd [1:0], put_id [11:2], zero [15:12]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // status [1:0], given_id [11:2], zero [15:12]
   input  logic                  csr_wen,
   input  logic [CSR_W-1:0]      csr_wdata
);

   // The used-bit map lives in a one-read, one-write memory of MAP_WORDS words.
   // Counters that hold ids, limits and word bases share one width, CNT_W, wide
   // enough for the register value and for a base one word past the end.
   localparam int MAP_WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
   localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int WPW       = $clog2(MAP_WORDS + 1);
   localparam int BW        = $clog2(WORD_BITS);
   localparam int SPAN_W    = $clog2((MAP_WORDS + 1) * WORD_BITS + 1);
   localparam int CNT_W     = (SPAN_W > CSR_W) ? SPAN_W : CSR_W;
   localparam int RESET_LIM = (MAX_IDS < LIMIT_RESET) ? MAX_IDS : LIMIT_RESET;

   localparam logic [CNT_W-1:0] WB_STEP   = CNT_W'(WORD_BITS);
   localparam logic [CNT_W-1:0] MAX_LIM   = CNT_W'(MAX_IDS);
   localparam logic [BW-1:0]    LAST_BIT  = BW'(WORD_BITS - 1);
   localparam logic [WPW-1:0]   LAST_WORD = WPW'(MAP_WORDS - 1);

   state_type state_ff, state_in;

   // Effective limit, already saturated to MAX_IDS when the register is written.
   logic [CNT_W-1:0] lim_ff, lim_in;
   logic [CNT_W-1:0] used_ff, used_in;

   // Start of the next increasing scan, kept as word, word base and bit so that
   // no division is needed to find its word.
   logic [WPW-1:0]   ns_word_ff, ns_word_in;
   logic [CNT_W-1:0] ns_base_ff, ns_base_in;
   logic [BW-1:0]    ns_bit_ff, ns_bit_in;

   // Read pointer: word issued to the memory and its base id. It also serves as
   // the clearing counter and as the word walker of a free.
   logic [WPW-1:0]   rd_word_ff, rd_word_in;
   logic [CNT_W-1:0] rd_base_ff, rd_base_in;

   // Word under check: the one whose data the memory shows this cycle.
   logic             chk_valid_ff, chk_valid_in;
   logic [WPW-1:0]   chk_word_ff, chk_word_in;
   logic [CNT_W-1:0] chk_base_ff, chk_base_in;
   logic [BW-1:0]    chk_lo_ff, chk_lo_in;

   logic [ID_W-1:0]  pid_ff, pid_in;
   logic [ST_W-1:0]  res_status_ff, res_status_in;
   logic [ID_W-1:0]  res_id_ff, res_id_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic                 mem_wr_en;
   logic [AW-1:0]        mem_wr_addr;
   logic [WORD_BITS-1:0] mem_wr_data;
   logic [AW-1:0]        mem_rd_addr;
   logic [WORD_BITS-1:0] mem_rd_data;

   logic                 scan_found;
   logic [BW-1:0]        scan_bit;

   logic                 req_fire;
   logic [CMD_W-1:0]     req_cmd;
   logic [ID_W-1:0]      req_pid;
   logic                 is_get;
   logic                 map_full;
   logic [CNT_W-1:0]     ns_lin;
   logic                 use_ns;
   logic [WPW-1:0]       start_word;
   logic [CNT_W-1:0]     start_base;
   logic [BW-1:0]        start_lo;
   logic                 issue_ok;
   logic                 seek_hit;
   logic [CNT_W-1:0]     hit_id;
   logic [BW-1:0]        put_bit;
   logic                 put_used;
   logic                 out_free;

   // ------------------------------------------------------------------
   // Map memory and the word scanner, the one unit that every get reuses.
   // ------------------------------------------------------------------
   bia_map_ram #(
      .DEPTH (MAP_WORDS),
      .WIDTH (WORD_BITS),
      .AW    (AW)
   ) u_map (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   bia_word_scan #(
      .WORD_BITS (WORD_BITS),
      .CNT_W     (CNT_W)
   ) u_scan (
      .map_word (mem_rd_data),
      .base     (chk_base_ff),
      .lo       (chk_lo_ff),
      .lim      (lim_ff),
      .found    (scan_found),
      .bit_idx  (scan_bit)
   );

   // ------------------------------------------------------------------
   // Decode of the request word and of the sequencer's conditions.
   // ------------------------------------------------------------------
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_cmd    = req_tdata[CMD_W-1:0];
   assign req_pid    = req_tdata[CMD_W +: ID_W];
   assign is_get     = (req_cmd == CMD_GET_LOW) || (req_cmd == CMD_GET_NEXT);

   // The full test uses >= so that a lowered limit with ids still in use
   // keeps answering busy.
   assign map_full = (used_ff >= lim_ff);
   assign ns_lin   = ns_base_ff + CNT_W'(ns_bit_ff);
   assign use_ns   = (req_cmd == CMD_GET_NEXT) && (ns_lin < lim_ff);

   // An increasing get starts at the stored pointer while it lies below the limit; everything else at id zero.
   assign start_word = use_ns ? ns_word_ff : '0;
   assign start_base = use_ns ? ns_base_ff : '0;
   assign start_lo   = use_ns ? ns_bit_ff  : '0;

   // A word is fetched only while its first id is below the limit.
   assign issue_ok = (rd_base_ff < lim_ff);
   assign seek_hit = (CNT_W'(pid_ff) < rd_base_ff + WB_STEP);
   assign hit_id   = chk_base_ff + CNT_W'(scan_bit);
   assign put_bit  = BW'(CNT_W'(pid_ff) - chk_base_ff);
   assign put_used = mem_rd_data[put_bit];
   assign out_free = !rsp_valid_ff || rsp_tready;

   // ------------------------------------------------------------------
   // Next state.
   // ------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (rd_word_ff == LAST_WORD) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_fire) begin
               if (is_get) begin
                  state_in = map_full ? S_DONE : S_SCAN;
               end else if (req_cmd == CMD_PUT) begin
                  state_in = (CNT_W'(req_pid) >= lim_ff) ? S_DONE : S_SEEK;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_SCAN: begin
            // Stop on a hit, or once the pipeline has run dry below the limit.
            if (!chk_valid_ff || scan_found) begin
               state_in = S_DONE;
            end
         end
         S_SEEK: begin
            if (seek_hit) begin
               state_in = S_FREE_CHK;
            end
         end
         S_FREE_CHK: begin
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Datapath and memory control.
   // ------------------------------------------------------------------
   always_comb begin
      lim_in        = lim_ff;
      used_in       = used_ff;
      ns_word_in    = ns_word_ff;
      ns_base_in    = ns_base_ff;
      ns_bit_in     = ns_bit_ff;
      rd_word_in    = rd_word_ff;
      rd_base_in    = rd_base_ff;
      chk_valid_in  = 1'b0;
      chk_word_in   = chk_word_ff;
      chk_base_in   = chk_base_ff;
      chk_lo_in     = chk_lo_ff;
      pid_in        = pid_ff;
      res_status_in = res_status_ff;
      res_id_in     = res_id_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      mem_wr_en     = 1'b0;
      mem_wr_addr   = chk_word_ff[AW-1:0];
      mem_wr_data   = '0;
      mem_rd_addr   = rd_word_ff[AW-1:0];

      // The limit register may be written in any state; values above MAX_IDS saturate.
      if (csr_wen) begin
         lim_in = (CNT_W'(csr_wdata) > MAX_LIM) ? MAX_LIM : CNT_W'(csr_wdata);
      end

      case (state_ff)
         S_CLEAR: begin
            // One map word is zeroed per cycle after reset.
            mem_wr_en   = 1'b1;
            mem_wr_addr = rd_word_ff[AW-1:0];
            rd_word_in  = rd_word_ff + WPW'(1);
         end
         S_IDLE: begin
            if (req_fire) begin
               pid_in        = req_pid;
               res_status_in = STS_OK;
               res_id_in     = '0;
               if (is_get) begin
                  if (map_full) begin
                     res_status_in = STS_BUSY;
                  end else begin
                     // The pointer has reached the limit: an increasing get
                     // restarts from zero and the pointer goes back to zero.
                     if ((req_cmd == CMD_GET_NEXT) && !use_ns) begin
                        ns_word_in = '0;
                        ns_base_in = '0;
                        ns_bit_in  = '0;
                     end
                     // The first word is fetched right away.
                     mem_rd_addr  = start_word[AW-1:0];
                     chk_valid_in = 1'b1;
                     chk_word_in  = start_word;
                     chk_base_in  = start_base;
                     chk_lo_in    = start_lo;
                     rd_word_in   = start_word + WPW'(1);
                     rd_base_in   = start_base + WB_STEP;
                  end
               end else if (req_cmd == CMD_PUT) begin
                  if (CNT_W'(req_pid) >= lim_ff) begin
                     res_status_in = STS_BAD;
                  end else begin
                     rd_word_in = '0;
                     rd_base_in = '0;
                  end
               end else begin
                  res_status_in = STS_BAD;
               end
            end
         end
         S_SCAN: begin
            // Fetch the next word while the scanner checks the current one.
            if (issue_ok) begin
               chk_valid_in = 1'b1;
               chk_word_in  = rd_word_ff;
               chk_base_in  = rd_base_ff;
               chk_lo_in    = '0;
               rd_word_in   = rd_word_ff + WPW'(1);
               rd_base_in   = rd_base_ff + WB_STEP;
            end
            if (chk_valid_ff && scan_found) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_word_ff[AW-1:0];
               mem_wr_data = mem_rd_data | (WORD_BITS'(1) << scan_bit);
               used_in     = used_ff + CNT_W'(1);
               res_id_in   = hit_id[ID_W-1:0];
               // A hit at or past the pointer moves it upward, to one past the id just given.
               if (hit_id >= ns_lin) begin
                  if (scan_bit == LAST_BIT) begin
                     ns_word_in = chk_word_ff + WPW'(1);
                     ns_base_in = chk_base_ff + WB_STEP;
                     ns_bit_in  = '0;
                  end else begin
                     ns_word_in = chk_word_ff;
                     ns_base_in = chk_base_ff;
                     ns_bit_in  = scan_bit + BW'(1);
                  end
               end
            end else if (!chk_valid_ff) begin
               res_status_in = STS_BUSY;
            end
         end
         S_SEEK: begin
            // Walk word bases until the one holding the freed id, then fetch it.
            if (seek_hit) begin
               chk_word_in = rd_word_ff;
               chk_base_in = rd_base_ff;
            end else begin
               rd_word_in = rd_word_ff + WPW'(1);
               rd_base_in = rd_base_ff + WB_STEP;
            end
         end
         S_FREE_CHK: begin
            if (put_used) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = chk_word_ff[AW-1:0];
               mem_wr_data = mem_rd_data & ~(WORD_BITS'(1) << put_bit);
               used_in     = (used_ff != '0) ? (used_ff - CNT_W'(1)) : used_ff;
            end else begin
               res_status_in = STS_BAD;
            end
         end
         S_DONE: begin
            // The result moves to the output register once it is empty or being taken.
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD{1'b0}}, res_id_ff, res_status_ff};
            end
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------
   // Registers.
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lim_ff       <= CNT_W'(RESET_LIM);
         used_ff      <= '0;
         ns_word_ff   <= '0;
         ns_base_ff   <= '0;
         ns_bit_ff    <= '0;
         rd_word_ff   <= '0;
         rd_base_ff   <= '0;
         chk_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lim_ff       <= lim_in;
         used_ff      <= used_in;
         ns_word_ff   <= ns_word_in;
         ns_base_ff   <= ns_base_in;
         ns_bit_ff    <= ns_bit_in;
         rd_word_ff   <= rd_word_in;
         rd_base_ff   <= rd_base_in;
         chk_valid_ff <= chk_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      chk_word_ff   <= chk_word_in;
      chk_base_ff   <= chk_base_in;
      chk_lo_ff     <= chk_lo_in;
      pid_ff        <= pid_in;
      res_status_ff <= res_status_in;
      res_id_ff     <= res_id_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

// ===== src/bia_checker.sv =====
`include "assert_macros.svh"

module bia_checker
   import bia_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tvalid,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic [ST_W-1:0] rsp_status;
   logic [ID_W-1:0] rsp_id;
   logic            rsp_stall;
   logic            rsp_fail;
   logic            status_known;
   logic            req_fire;

   assign rsp_status   = rsp_tdata[ST_W-1:0];
   assign rsp_id       = rsp_tdata[ST_W +: ID_W];
   assign rsp_stall    = rsp_tvalid && !rsp_tready;
   assign rsp_fail     = rsp_tvalid && (rsp_status != STS_OK);
   assign status_known = (rsp_status == STS_OK) || (rsp_status == STS_BUSY) ||
                         (rsp_status == STS_BAD);
   assign req_fire     = req_tvalid && req_tready;

   // A response word that is not taken stays on the port unchanged.
   `BIA_ASSERT_NEXT(a_hold_valid, clock, reset, rsp_stall, rsp_tvalid, "response dropped")
   `BIA_ASSERT_NEXT(a_hold_data, clock, reset, rsp_stall, $stable(rsp_tdata), "data moved")

   // Only the three defined status codes appear.
   `BIA_ASSERT_IMPL(a_rsp_status, clock, reset, rsp_tvalid, status_known, "bad status code")

   // A busy or bad answer carries id zero.
   `BIA_ASSERT_IMPL(a_rsp_id_zero, clock, reset, rsp_fail, rsp_id == '0, "id on failed request")

   // The allocator works on one request at a time.
   `BIA_ASSERT_NEXT(a_one_at_a_time, clock, reset, req_fire, !req_tready, "second request taken")

endmodule

bind bitmap_id_allocator bia_checker u_bia_checker (.*);
